// ===== rtl/q2e_pkg.sv =====
`default_nettype none
package q2e_pkg;

  // input component width, Q1.15
  localparam int Q_W = 16;
  // product of two components, Q2.30
  localparam int P_W = 32;
  // singularity test and its double
  localparam int T_W = 34;
  // clamped asin argument, range -2^30..2^30
  localparam int S_W = 32;
  // atan2 operand vectors before normalization
  localparam int VEC_W = 35;
  // CORDIC datapath width
  localparam int CW = 45;
  // angle accumulator, degrees times 65536
  localparam int ANG_W = 26;
  // rounding datapath, holds twice an angle
  localparam int RND_W = 28;
  // square root remainder and root
  localparam int SQ_W = 62;
  localparam int ROOT_W = 31;
  localparam int THR_W = 15;

  localparam int NORM_STEPS = 6;
  localparam int CORDIC_STEPS = 20;
  localparam int SQRT_STEPS = 31;
  // normalized magnitude lies in [2^(NORM_TOP-1), 2^NORM_TOP)
  localparam int NORM_TOP = 41;
  localparam int FRONT_LAT = 4;
  localparam int LANE_LAT = 1 + NORM_STEPS + CORDIC_STEPS;
  localparam int TOTAL_LAT = FRONT_LAT + SQRT_STEPS + LANE_LAT;

  localparam logic [THR_W-1:0] THR_RESET = 15'd16351;
  localparam logic signed [ANG_W-1:0] DEG180 = 26'sd11796480;
  localparam logic signed [15:0] PITCH_POLE = 16'sd11520;
  localparam logic signed [T_W-1:0] ONE_Q30 = 34'sd1073741824;

  typedef enum logic [1:0] {
    POLE_NONE  = 2'd0,
    POLE_NORTH = 2'd1,
    POLE_SOUTH = 2'd2
  } pole_t;

  typedef struct packed {
    logic                    zero;
    logic signed [CW-1:0]    x;
    logic signed [CW-1:0]    y;
    logic        [CW-1:0]    m;
    logic signed [ANG_W-1:0] ang;
  } cord_t;

  typedef struct packed {
    logic signed [S_W-1:0]   s;
    logic signed [VEC_W-1:0] yaw_y;
    logic signed [VEC_W-1:0] yaw_x;
    logic signed [VEC_W-1:0] roll_y;
    logic signed [VEC_W-1:0] roll_x;
    pole_t                   pole;
  } side_t;

  typedef struct packed {
    logic [SQ_W-1:0]   rem;
    logic [ROOT_W-1:0] q;
    side_t             side;
  } sqrt_t;

  // atan(2^-i) in degrees times 65536
  function automatic logic signed [ANG_W-1:0] atan_lut(input logic [4:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:  v = 26'sd2949120;
      5'd1:  v = 26'sd1740967;
      5'd2:  v = 26'sd919879;
      5'd3:  v = 26'sd466945;
      5'd4:  v = 26'sd234379;
      5'd5:  v = 26'sd117304;
      5'd6:  v = 26'sd58666;
      5'd7:  v = 26'sd29335;
      5'd8:  v = 26'sd14668;
      5'd9:  v = 26'sd7334;
      5'd10: v = 26'sd3667;
      5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;
      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;
      5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;
      5'd19: v = 26'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/q2e_if.sv =====
`default_nettype none
interface q2e_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [q2e_pkg::Q_W-1:0] quat_w;
  logic signed [q2e_pkg::Q_W-1:0] quat_x;
  logic signed [q2e_pkg::Q_W-1:0] quat_y;
  logic signed [q2e_pkg::Q_W-1:0] quat_z;
  modport source(output valid, output quat_w, output quat_x, output quat_y,
                 output quat_z, input ready);
  modport sink(input valid, input quat_w, input quat_x, input quat_y,
               input quat_z, output ready);
endinterface

interface q2e_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] yaw_deg;
  logic signed [14:0] pitch_deg;
  logic signed [15:0] roll_deg;
  logic [1:0]         pole_case;
  modport source(output valid, output yaw_deg, output pitch_deg, output roll_deg,
                 output pole_case, input ready);
  modport sink(input valid, input yaw_deg, input pitch_deg, input roll_deg,
               input pole_case, output ready);
endinterface
`default_nettype wire

// ===== rtl/q2e_sqrt_cell.sv =====
`default_nettype none
module q2e_sqrt_cell (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [4:0]      bpos,
  input  q2e_pkg::sqrt_t       d_in,
  output q2e_pkg::sqrt_t       d_out
);
  q2e_pkg::sqrt_t               d_r;
  q2e_pkg::sqrt_t               d_nxt;
  logic [q2e_pkg::SQ_W-1:0]     add;

  // try setting root bit bpos: subtract (2q + 2^b) * 2^b when it fits
  always_comb begin
    add = (q2e_pkg::SQ_W'(d_in.q) << (6'(bpos) + 6'd1))
        + (q2e_pkg::SQ_W'(1) << {bpos, 1'b0});
    d_nxt = d_in;
    if (d_in.rem >= add) begin
      d_nxt.rem = d_in.rem - add;
      d_nxt.q   = d_in.q | (q2e_pkg::ROOT_W'(1) << bpos);
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign d_out = d_r;
endmodule
`default_nettype wire

// ===== rtl/q2e_norm_cell.sv =====
`default_nettype none
module q2e_norm_cell (
  input  wire logic       clk,
  input  wire logic       en,
  input  wire logic [5:0] shamt,
  input  q2e_pkg::cord_t  d_in,
  output q2e_pkg::cord_t  d_out
);
  q2e_pkg::cord_t d_r;
  q2e_pkg::cord_t d_nxt;
  logic           fits;

  // shift up by shamt when the magnitude stays below the normalization ceiling
  always_comb begin
    fits  = (d_in.m >> (6'(q2e_pkg::NORM_TOP) - shamt)) == '0;
    d_nxt = d_in;
    if (fits) begin
      d_nxt.x = d_in.x <<< shamt;
      d_nxt.y = d_in.y <<< shamt;
      d_nxt.m = d_in.m << shamt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign d_out = d_r;
endmodule
`default_nettype wire

// ===== rtl/q2e_cordic_cell.sv =====
`default_nettype none
module q2e_cordic_cell (
  input  wire logic       clk,
  input  wire logic       en,
  input  wire logic [4:0] idx,
  input  q2e_pkg::cord_t  d_in,
  output q2e_pkg::cord_t  d_out
);
  q2e_pkg::cord_t                 d_r;
  q2e_pkg::cord_t                 d_nxt;
  logic signed [q2e_pkg::CW-1:0]  xs;
  logic signed [q2e_pkg::CW-1:0]  ys;

  // rotate toward the x axis by atan(2^-idx)
  always_comb begin
    xs    = d_in.x >>> idx;
    ys    = d_in.y >>> idx;
    d_nxt = d_in;
    if (!d_in.y[q2e_pkg::CW-1]) begin
      d_nxt.x   = d_in.x + ys;
      d_nxt.y   = d_in.y - xs;
      d_nxt.ang = d_in.ang + q2e_pkg::atan_lut(idx);
    end else begin
      d_nxt.x   = d_in.x - ys;
      d_nxt.y   = d_in.y + xs;
      d_nxt.ang = d_in.ang - q2e_pkg::atan_lut(idx);
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign d_out = d_r;
endmodule
`default_nettype wire

// ===== rtl/q2e_atan_lane.sv =====
`default_nettype none
module q2e_atan_lane (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [q2e_pkg::CW-1:0]     vy,
  input  wire logic signed [q2e_pkg::CW-1:0]     vx,
  output logic signed [q2e_pkg::ANG_W-1:0]       angle
);
  localparam int LAST = q2e_pkg::NORM_STEPS + q2e_pkg::CORDIC_STEPS;

  q2e_pkg::cord_t                prep_r;
  q2e_pkg::cord_t                prep_nxt;
  q2e_pkg::cord_t                chain [LAST+1];
  logic signed [q2e_pkg::CW-1:0] ny;

  // fold the left half plane onto the right, note the zero vector
  always_comb begin
    prep_nxt.zero = (vx == '0) && (vy == '0);
    prep_nxt.ang  = '0;
    prep_nxt.x    = vx;
    prep_nxt.y    = vy;
    if (vx[q2e_pkg::CW-1]) begin
      prep_nxt.ang = vy[q2e_pkg::CW-1] ? -q2e_pkg::DEG180 : q2e_pkg::DEG180;
      prep_nxt.x   = -vx;
      prep_nxt.y   = -vy;
    end
    ny         = prep_nxt.y[q2e_pkg::CW-1] ? -prep_nxt.y : prep_nxt.y;
    prep_nxt.m = prep_nxt.x | ny;
  end

  always_ff @(posedge clk) begin
    if (en) prep_r <= prep_nxt;
  end

  assign chain[0] = prep_r;

  for (genvar i = 0; i < q2e_pkg::NORM_STEPS; i++) begin : g_norm
    q2e_norm_cell u_norm (
      .clk  (clk),
      .en   (en),
      .shamt(6'(32 >> i)),
      .d_in (chain[i]),
      .d_out(chain[i+1])
    );
  end

  for (genvar i = 0; i < q2e_pkg::CORDIC_STEPS; i++) begin : g_rot
    q2e_cordic_cell u_rot (
      .clk  (clk),
      .en   (en),
      .idx  (5'(i)),
      .d_in (chain[q2e_pkg::NORM_STEPS+i]),
      .d_out(chain[q2e_pkg::NORM_STEPS+i+1])
    );
  end

  assign angle = chain[LAST].zero ? '0 : chain[LAST].ang;
endmodule
`default_nettype wire

// ===== rtl/quaternion_to_euler_angles.sv =====
`default_nettype none
// Channel  Port      Dir  Word
// input    in_ch     in   quat_w, quat_x, quat_y, quat_z (signed Q1.15)
// result   out_ch    out  yaw_deg, pitch_deg, roll_deg, pole_case
// config   cfg_*     in   pole_threshold (Q0.15) on cfg_wdata when cfg_we
//
// One word enters per cycle while the output is not stalled; each result is
// offered after passing through 63 registers, the first loaded at the taking
// edge: 4 front stages (products, sums, square, remainder), 31 square root
// cells for the pitch cosine, and 27 stages per atan2 lane (fold, 6 normalize
// cells, 20 CORDIC cells), then the output register.
// Reset clears the valid pipeline and loads the default threshold.
// A result not taken holds the whole pipeline, input included.
module quaternion_to_euler_angles (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  q2e_in_if.sink                           in_ch,
  q2e_out_if.source                        out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [q2e_pkg::THR_W-1:0]   cfg_wdata
);
  typedef struct packed {
    logic signed [q2e_pkg::P_W-1:0] xy, zw, yw, xz, yy, zz, xw, yz, xx;
    logic signed [q2e_pkg::Q_W-1:0] x, w;
  } prod_t;

  logic                            adv;
  logic [q2e_pkg::THR_W-1:0]       thr_r;
  logic [q2e_pkg::TOTAL_LAT-1:0]   vld_r;
  prod_t                           prod_r;
  q2e_pkg::side_t                  side2_r;
  q2e_pkg::side_t                  side2_nxt;
  q2e_pkg::side_t                  side3_r;
  logic [q2e_pkg::SQ_W-1:0]        sq_r;
  q2e_pkg::sqrt_t                  sq4_r;
  q2e_pkg::sqrt_t                  sq_chain [q2e_pkg::SQRT_STEPS+1];
  q2e_pkg::pole_t                  pole_dly_r [q2e_pkg::LANE_LAT];
  logic signed [q2e_pkg::T_W-1:0]  test;
  logic signed [q2e_pkg::T_W-1:0]  thr_ext;
  logic signed [q2e_pkg::T_W-1:0]  t2;
  logic signed [2*q2e_pkg::S_W-1:0] s_sq;
  logic signed [q2e_pkg::ANG_W-1:0] yaw_a, pitch_a, roll_a;
  logic signed [q2e_pkg::RND_W-1:0] yaw_scaled;
  q2e_pkg::pole_t                  pole_end;
  logic                            out_valid_r;
  logic signed [16:0]              yaw_r, yaw_nxt;
  logic signed [14:0]              pitch_r, pitch_nxt;
  logic signed [15:0]              roll_r, roll_nxt;
  logic [1:0]                      pole_r;

  function automatic logic signed [q2e_pkg::RND_W-1:0] to_q7(
      input logic signed [q2e_pkg::RND_W-1:0] a);
    logic signed [q2e_pkg::RND_W-1:0] sum;
    sum = a + q2e_pkg::RND_W'(256);
    return sum >>> 9;
  endfunction

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= q2e_pkg::THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // advance valid bits with the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[q2e_pkg::TOTAL_LAT-2:0], in_ch.valid};
      out_valid_r <= vld_r[q2e_pkg::TOTAL_LAT-1];
    end
  end

  // stage 1: the nine component products used, with x and w passed along
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r.xy <= in_ch.quat_x * in_ch.quat_y;
      prod_r.zw <= in_ch.quat_z * in_ch.quat_w;
      prod_r.yw <= in_ch.quat_y * in_ch.quat_w;
      prod_r.xz <= in_ch.quat_x * in_ch.quat_z;
      prod_r.yy <= in_ch.quat_y * in_ch.quat_y;
      prod_r.zz <= in_ch.quat_z * in_ch.quat_z;
      prod_r.xw <= in_ch.quat_x * in_ch.quat_w;
      prod_r.yz <= in_ch.quat_y * in_ch.quat_z;
      prod_r.xx <= in_ch.quat_x * in_ch.quat_x;
      prod_r.x  <= in_ch.quat_x;
      prod_r.w  <= in_ch.quat_w;
    end
  end

  // stage 2: pole test, atan2 operand vectors, clamped asin argument
  always_comb begin
    test    = q2e_pkg::T_W'(prod_r.xy) + q2e_pkg::T_W'(prod_r.zw);
    thr_ext = $signed({4'b0000, thr_r, 15'b0});
    t2      = test <<< 1;
    side2_nxt.roll_y = (q2e_pkg::VEC_W'(prod_r.xw) - q2e_pkg::VEC_W'(prod_r.yz)) <<< 1;
    side2_nxt.roll_x = q2e_pkg::VEC_W'(q2e_pkg::ONE_Q30)
                     - ((q2e_pkg::VEC_W'(prod_r.xx) + q2e_pkg::VEC_W'(prod_r.zz)) <<< 1);
    if (t2 > q2e_pkg::ONE_Q30) begin
      side2_nxt.s = q2e_pkg::S_W'(q2e_pkg::ONE_Q30);
    end else if (t2 < -q2e_pkg::ONE_Q30) begin
      side2_nxt.s = q2e_pkg::S_W'(-q2e_pkg::ONE_Q30);
    end else begin
      side2_nxt.s = q2e_pkg::S_W'(t2);
    end
    if (test > thr_ext) begin
      side2_nxt.pole = q2e_pkg::POLE_NORTH;
    end else if (test < -thr_ext) begin
      side2_nxt.pole = q2e_pkg::POLE_SOUTH;
    end else begin
      side2_nxt.pole = q2e_pkg::POLE_NONE;
    end
    if (side2_nxt.pole != q2e_pkg::POLE_NONE) begin
      side2_nxt.yaw_y = q2e_pkg::VEC_W'(prod_r.x);
      side2_nxt.yaw_x = q2e_pkg::VEC_W'(prod_r.w);
    end else begin
      side2_nxt.yaw_y = (q2e_pkg::VEC_W'(prod_r.yw) - q2e_pkg::VEC_W'(prod_r.xz)) <<< 1;
      side2_nxt.yaw_x = q2e_pkg::VEC_W'(q2e_pkg::ONE_Q30)
                      - ((q2e_pkg::VEC_W'(prod_r.yy) + q2e_pkg::VEC_W'(prod_r.zz)) <<< 1);
    end
  end

  assign s_sq = side2_r.s * side2_r.s;

  // stages 2 to 4: register vectors, square the argument, form the remainder
  always_ff @(posedge clk) begin
    if (adv) begin
      side2_r        <= side2_nxt;
      side3_r        <= side2_r;
      sq_r           <= q2e_pkg::SQ_W'(s_sq);
      sq4_r.rem      <= (q2e_pkg::SQ_W'(1) << 60) - sq_r;
      sq4_r.q        <= '0;
      sq4_r.side     <= side3_r;
    end
  end

  assign sq_chain[0] = sq4_r;

  for (genvar i = 0; i < q2e_pkg::SQRT_STEPS; i++) begin : g_sqrt
    q2e_sqrt_cell u_sqrt (
      .clk  (clk),
      .en   (adv),
      .bpos (5'(q2e_pkg::SQRT_STEPS - 1 - i)),
      .d_in (sq_chain[i]),
      .d_out(sq_chain[i+1])
    );
  end

  q2e_atan_lane u_yaw (
    .clk  (clk),
    .en   (adv),
    .vy   (q2e_pkg::CW'(sq_chain[q2e_pkg::SQRT_STEPS].side.yaw_y)),
    .vx   (q2e_pkg::CW'(sq_chain[q2e_pkg::SQRT_STEPS].side.yaw_x)),
    .angle(yaw_a)
  );

  q2e_atan_lane u_pitch (
    .clk  (clk),
    .en   (adv),
    .vy   (q2e_pkg::CW'(sq_chain[q2e_pkg::SQRT_STEPS].side.s)),
    .vx   (q2e_pkg::CW'($signed({1'b0, sq_chain[q2e_pkg::SQRT_STEPS].q}))),
    .angle(pitch_a)
  );

  q2e_atan_lane u_roll (
    .clk  (clk),
    .en   (adv),
    .vy   (q2e_pkg::CW'(sq_chain[q2e_pkg::SQRT_STEPS].side.roll_y)),
    .vx   (q2e_pkg::CW'(sq_chain[q2e_pkg::SQRT_STEPS].side.roll_x)),
    .angle(roll_a)
  );

  // delay the pole code alongside the lanes
  always_ff @(posedge clk) begin
    if (adv) begin
      pole_dly_r[0] <= sq_chain[q2e_pkg::SQRT_STEPS].side.pole;
      for (int i = 1; i < q2e_pkg::LANE_LAT; i++) begin
        pole_dly_r[i] <= pole_dly_r[i-1];
      end
    end
  end

  assign pole_end = pole_dly_r[q2e_pkg::LANE_LAT-1];

  // scale, round and select the result word
  always_comb begin
    case (pole_end)
      q2e_pkg::POLE_NORTH: yaw_scaled = q2e_pkg::RND_W'(yaw_a) <<< 1;
      q2e_pkg::POLE_SOUTH: yaw_scaled = -(q2e_pkg::RND_W'(yaw_a) <<< 1);
      default:             yaw_scaled = q2e_pkg::RND_W'(yaw_a);
    endcase
    yaw_nxt = 17'(to_q7(yaw_scaled));
    case (pole_end)
      q2e_pkg::POLE_NORTH: begin
        pitch_nxt = q2e_pkg::PITCH_POLE[14:0];
        roll_nxt  = '0;
      end
      q2e_pkg::POLE_SOUTH: begin
        pitch_nxt = -q2e_pkg::PITCH_POLE[14:0];
        roll_nxt  = '0;
      end
      default: begin
        pitch_nxt = 15'(to_q7(q2e_pkg::RND_W'(pitch_a)));
        roll_nxt  = 16'(to_q7(q2e_pkg::RND_W'(roll_a)));
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      yaw_r   <= yaw_nxt;
      pitch_r <= pitch_nxt;
      roll_r  <= roll_nxt;
      pole_r  <= pole_end;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.yaw_deg   = yaw_r;
  assign out_ch.pitch_deg = pitch_r;
  assign out_ch.roll_deg  = roll_r;
  assign out_ch.pole_case = pole_r;
endmodule
`default_nettype wire

// ===== rtl/q2e_checker.sv =====
`default_nettype none
module q2e_props (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic signed [14:0] pitch_deg,
  input wire logic signed [15:0] roll_deg,
  input wire logic [1:0]        pole_case
);
  // a stalled result word stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // north pole gives pitch +90 and no roll
  a_north: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && pole_case == q2e_pkg::POLE_NORTH
    |-> pitch_deg == 15'sd11520 && roll_deg == 16'sd0)
    else $error("north pole angles wrong");

  // south pole gives pitch -90 and no roll
  a_south: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && pole_case == q2e_pkg::POLE_SOUTH
    |-> pitch_deg == -15'sd11520 && roll_deg == 16'sd0)
    else $error("south pole angles wrong");

  // pole code is one of the defined codes
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pole_case == q2e_pkg::POLE_NONE || pole_case == q2e_pkg::POLE_NORTH
                  || pole_case == q2e_pkg::POLE_SOUTH)
    else $error("bad pole code");
endmodule

bind quaternion_to_euler_angles q2e_props u_q2e_props (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .pitch_deg(out_ch.pitch_deg),
  .roll_deg (out_ch.roll_deg),
  .pole_case(out_ch.pole_case)
);
`default_nettype wire
